[rtl/matrix_range_add_rect_sum_unit_macros.svh]
// assertion macros for the matrix range-add rectangle-sum unit
`ifndef MATRIX_RANGE_ADD_RECT_SUM_UNIT_MACROS_SVH
`define MATRIX_RANGE_ADD_RECT_SUM_UNIT_MACROS_SVH
// implication checked on every edge outside reset
`define MRAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// condition that holds at every edge outside reset
`define MRAS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

[rtl/mras_pkg.sv]
// shared types and codes for the matrix range-add rectangle-sum unit
package mras_pkg;
  localparam int unsigned DataW = 32;
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_BUILD = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;
  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;
  typedef logic [DataW-1:0] word_t;
endpackage

[rtl/matrix_range_add_rect_sum_unit.sv]
// top level of the matrix range-add rectangle-sum unit
// Usage: items arrive on the in_ channel (tdata holds action, row_first, col_first, row_last,
// col_last, value from the lowest bit up). Only queries (action 3) produce a word on the out_
// channel: tdata holds rect_sum in bits 31:0 and query_error in bit 32.
// One item is worked at a time by a sequencer around four memories (matrix, difference,
// adjusted, summed table), each with a registered read.
// Steps per item: a load writes at most one entry; a range add reads and then writes each of
// four corners; a query makes four table reads, a sum step and the result register; a build
// makes two passes over the grid, reading and then writing each entry.
// A query result reaches out_tvalid through S_Q_RD, S_Q_SUM, S_OUT and the result register.
// After reset a clearing pass over every memory entry (256 with the default sizes)
// zeroes the matrix and difference memories; no item is taken meanwhile, configuration
// writes are taken.
// The result register holds its word while out_tready is low; items are still accepted,
// and a later query waits at its last step until the held word has been taken.
// cfg_addr 0 is rows_in_use, 1 is cols_in_use; both reset to the maximum.
module matrix_range_add_rect_sum_unit #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // action, row_first, col_first, row_last, col_last, value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // rect_sum, query_error, zero fill
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_wdata
);
  import mras_pkg::*;
  `include "matrix_range_add_rect_sum_unit_macros.svh"

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;
  localparam int Cells = 1 << AW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_ADD_RD, S_ADD_WR, S_Q_RD, S_Q_SUM,
    S_B1_RD, S_B1_WR, S_B2_RD, S_B2_WR, S_OUT
  } state_t;

  word_t mat_mem [Cells];
  word_t dif_mem [Cells];
  word_t adj_mem [Cells];
  word_t sat_mem [Cells];

  state_t     state_r;
  logic [4:0] rows_r, cols_r;
  logic [5:0] nr, nc;
  logic [AW:0] clr_r;
  action_t    act_r;
  logic [4:0] r1_r, c1_r, r2_r, c2_r;
  word_t      val_r;
  logic [2:0] step_r;
  logic [5:0] bi_r, bj_r;
  word_t      acc_r;
  logic [32:0] res_r;
  logic        res_v_r;
  logic        res_load;

  // clamped grid extent
  always_comb begin
    nr = (rows_r == 5'd0) ? 6'd1 : ((32'(rows_r) > MAX_ROWS) ? 6'(MAX_ROWS) : {1'b0, rows_r});
    nc = (cols_r == 5'd0) ? 6'd1 : ((32'(cols_r) > MAX_COLS) ? 6'(MAX_COLS) : {1'b0, cols_r});
  end

  function automatic logic [AW-1:0] addr(input logic [5:0] r, input logic [5:0] c);
    addr = {r[RW-1:0], c[CW-1:0]};
  endfunction

  // corner / neighbour selection per step
  logic [5:0] cr, cc;
  logic       cok, cneg;
  always_comb begin
    cr = 6'd0; cc = 6'd0; cok = 1'b0; cneg = 1'b0;
    if (act_r == ACT_ADD) begin
      cr = step_r[0] ? {1'b0, r2_r} + 6'd1 : {1'b0, r1_r};
      cc = step_r[1] ? {1'b0, c2_r} + 6'd1 : {1'b0, c1_r};
      cneg = step_r[0] ^ step_r[1];
      cok = (cr < nr) && (cc < nc);
    end else if (act_r == ACT_QUERY) begin
      cr = step_r[0] ? {1'b0, r1_r} - 6'd1 : {1'b0, r2_r};
      cc = step_r[1] ? {1'b0, c1_r} - 6'd1 : {1'b0, c2_r};
      cneg = step_r[0] ^ step_r[1];
      cok = !(step_r[0] && r1_r == 5'd0) && !(step_r[1] && c1_r == 5'd0);
    end else begin
      // build: neighbours of (bi,bj): 0 self, 1 up, 2 left, 3 up-left
      cr = step_r[0] ? bi_r - 6'd1 : bi_r;
      cc = step_r[1] ? bj_r - 6'd1 : bj_r;
      cneg = step_r[0] & step_r[1];
      cok = !(step_r[0] && bi_r == 6'd0) && !(step_r[1] && bj_r == 6'd0);
    end
  end

  // memory ports: one read address, registered data
  logic [AW-1:0] rd_a;
  word_t mat_q, dif_q, adj_q, sat_q;
  logic  rd_ok_r;
  logic  rd_neg_r;
  logic  rd_self_r;
  assign rd_a = addr(cr, cc);
  always_ff @(posedge clk) begin
    mat_q <= mat_mem[rd_a];
    dif_q <= dif_mem[rd_a];
    adj_q <= adj_mem[rd_a];
    sat_q <= sat_mem[rd_a];
    rd_ok_r <= cok;
    rd_neg_r <= cneg;
    rd_self_r <= (step_r == 3'd0);
  end

  logic [55:0] d;
  logic bad_q;
  word_t term;
  assign d = in_tdata;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = res_v_r;
  assign out_tdata = {7'd0, res_r};
  assign bad_q = (r1_r > r2_r) || (c1_r > c2_r) || ({1'b0, r2_r} >= nr) || ({1'b0, c2_r} >= nc);
  // a finished query loads the result register once it is free
  assign res_load = (state_r == S_OUT) && (!res_v_r || out_tready);

  // term picked from the read wave
  always_comb begin
    term = '0;
    if (rd_ok_r) begin
      if (state_r == S_Q_RD || state_r == S_Q_SUM) term = sat_q;
      else if (state_r == S_B1_RD || state_r == S_B1_WR)
        term = (rd_self_r) ? dif_q : adj_q;
      else term = (rd_self_r) ? adj_q + mat_q : sat_q;
      if (rd_neg_r) term = -term;
    end
  end

  // sequencer, configuration and memory writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      rows_r <= 5'(MAX_ROWS);
      cols_r <= 5'(MAX_COLS);
      clr_r <= '0;
      res_v_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_ROWS) rows_r <= cfg_wdata;
        else rows_r <= rows_r;
        if (cfg_addr == REG_COLS) cols_r <= cfg_wdata;
      end
      if (res_load) res_v_r <= 1'b1;
      else if (out_tready) res_v_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          mat_mem[clr_r[AW-1:0]] <= '0;
          dif_mem[clr_r[AW-1:0]] <= '0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(Cells - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            act_r <= action_t'(d[1:0]);
            r1_r <= {1'b0, d[5:2]};
            c1_r <= {1'b0, d[9:6]};
            r2_r <= {1'b0, d[13:10]};
            c2_r <= {1'b0, d[17:14]};
            val_r <= d[49:18];
            step_r <= '0;
            bi_r <= '0;
            bj_r <= '0;
            acc_r <= '0;
            case (action_t'(d[1:0]))
              ACT_LOAD:  state_r <= S_LOAD;
              ACT_ADD:   state_r <= S_ADD_RD;
              ACT_BUILD: state_r <= S_B1_RD;
              default:   state_r <= S_Q_RD;
            endcase
          end
        end
        S_LOAD: begin
          if ({1'b0, r1_r} < nr && {1'b0, c1_r} < nc)
            mat_mem[addr({1'b0, r1_r}, {1'b0, c1_r})] <= val_r;
          state_r <= S_IDLE;
        end
        S_ADD_RD: state_r <= S_ADD_WR;
        S_ADD_WR: begin
          if (cok) dif_mem[rd_a] <= dif_q + (cneg ? -val_r : val_r);
          step_r <= step_r + 3'd1;
          state_r <= (step_r == 3'd3) ? S_IDLE : S_ADD_RD;
        end
        S_Q_RD: begin
          step_r <= step_r + 3'd1;
          state_r <= S_Q_SUM;
        end
        S_Q_SUM: begin
          acc_r <= acc_r + term;
          if (step_r == 3'd4) begin
            state_r <= S_OUT;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_OUT: begin
          if (res_load) begin
            res_r <= bad_q ? {1'b1, 32'd0} : {1'b0, acc_r};
            state_r <= S_IDLE;
          end
        end
        S_B1_RD, S_B2_RD: begin
          step_r <= step_r + 3'd1;
          state_r <= (state_r == S_B1_RD) ? S_B1_WR : S_B2_WR;
        end
        S_B1_WR, S_B2_WR: begin
          if (step_r != 3'd4) begin
            acc_r <= acc_r + term;
            step_r <= step_r + 3'd1;
          end else begin
            if (state_r == S_B1_WR) adj_mem[addr(bi_r, bj_r)] <= acc_r + term;
            else sat_mem[addr(bi_r, bj_r)] <= acc_r + term;
            acc_r <= '0;
            step_r <= '0;
            if (bj_r + 6'd1 < nc) begin
              bj_r <= bj_r + 6'd1;
              state_r <= (state_r == S_B1_WR) ? S_B1_RD : S_B2_RD;
            end else begin
              bj_r <= '0;
              if (bi_r + 6'd1 < nr) begin
                bi_r <= bi_r + 6'd1;
                state_r <= (state_r == S_B1_WR) ? S_B1_RD : S_B2_RD;
              end else begin
                bi_r <= '0;
                state_r <= (state_r == S_B1_WR) ? S_B2_RD : S_IDLE;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MRAS_ASSERT_IMP(a_ready_idle, in_tready, !(state_r == S_CLEAR), "ready during clear")
  `MRAS_ASSERT_IMP(a_res_hold, out_tvalid && !out_tready, ##1 out_tvalid, "result lost")
  `MRAS_ASSERT_IMP(a_res_stable, out_tvalid && !out_tready, ##1 $stable(out_tdata), "result moved")
  `MRAS_ASSERT_ALWAYS(a_step_rng, step_r <= 3'd4, "step overrun")
endmodule
